[sv/ttacc_pkg.sv]
// Shared types, constants and codes of the triangle tangent accumulator.
// No dependencies; every other file uses it by scoped names.
`default_nettype none
package ttacc_pkg;

    localparam int VERT_DEPTH = 4096;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 32;
    localparam int UV_W       = 16;
    localparam int SUM_W      = 48;
    localparam int TAN_W      = 16;
    localparam int DUV_W      = UV_W + 1;
    localparam int E_W        = POS_W + 1;
    localparam int DET_W      = 2 * DUV_W + 1;
    localparam int NP_W       = DUV_W + E_W;
    localparam int NUM_W      = NP_W + 1;
    localparam int DIV_NW     = 62;
    localparam int DIV_DW     = DET_W;
    localparam int DIV_CW     = 6;
    localparam int NORM_W     = 30;
    localparam int SQ_W       = 2 * NORM_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int SQ_CW      = 5;

    // Input operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Datapath micro-operations
    localparam logic [4:0] DP_NOP    = 5'd0;
    localparam logic [4:0] DP_LOAD   = 5'd1;
    localparam logic [4:0] DP_RD_A   = 5'd2;
    localparam logic [4:0] DP_RD_B   = 5'd3;
    localparam logic [4:0] DP_RD_C   = 5'd4;
    localparam logic [4:0] DP_UVMUL  = 5'd5;
    localparam logic [4:0] DP_DET    = 5'd6;
    localparam logic [4:0] DP_CLR    = 5'd7;
    localparam logic [4:0] DP_NMUL   = 5'd8;
    localparam logic [4:0] DP_NUM    = 5'd9;
    localparam logic [4:0] DP_TDIV   = 5'd10;
    localparam logic [4:0] DP_TSTORE = 5'd11;
    localparam logic [4:0] DP_SUMRD  = 5'd12;
    localparam logic [4:0] DP_SUMWR  = 5'd13;
    localparam logic [4:0] DP_VRD    = 5'd14;
    localparam logic [4:0] DP_MAG    = 5'd15;
    localparam logic [4:0] DP_MAX    = 5'd16;
    localparam logic [4:0] DP_SHIFT  = 5'd17;
    localparam logic [4:0] DP_SQ     = 5'd18;
    localparam logic [4:0] DP_SQACC  = 5'd19;
    localparam logic [4:0] DP_SQRT   = 5'd20;
    localparam logic [4:0] DP_UDIV   = 5'd21;
    localparam logic [4:0] DP_USTORE = 5'd22;
    localparam logic [4:0] DP_RES    = 5'd23;

    typedef struct packed {
        logic [4:0] uop;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_ok;
        logic       tri_ok;
        logic       det_zero;
        logic       m_zero;
        logic       shift_done;
        logic       k_last;
        logic       j_last;
        logic       div_done;
        logic       sqrt_done;
    } t_stat;

    function automatic logic f_idx_ok(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(VERT_DEPTH));
    endfunction

endpackage
`default_nettype wire

[sv/ttacc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the datapath.
// Depends on ttacc_pkg for operand widths.
`default_nettype none
module ttacc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ttacc_pkg::DIV_NW-1:0] i_num,
    input  wire logic [ttacc_pkg::DIV_DW-1:0] i_den,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [ttacc_pkg::DIV_NW-1:0]      o_quot
);
    logic                          r_busy, r_done;
    logic [ttacc_pkg::DIV_CW-1:0]  r_cnt;
    logic [ttacc_pkg::DIV_NW-1:0]  r_q;
    logic [ttacc_pkg::DIV_DW-1:0]  r_rem, r_den;
    logic [ttacc_pkg::DIV_DW:0]    w_sh, w_diff;
    logic                          w_ge;

    assign w_sh   = {r_rem, r_q[ttacc_pkg::DIV_NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ttacc_pkg::DIV_CW'(ttacc_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ttacc_pkg::DIV_DW-1:0] : w_sh[ttacc_pkg::DIV_DW-1:0];
            r_q   <= {r_q[ttacc_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[sv/ttacc_sqrt.sv]
// Integer square root, one result bit per cycle (bit-pair method).
// Depends on ttacc_pkg for widths.
`default_nettype none
module ttacc_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ttacc_pkg::SQ_W-1:0] i_val,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [ttacc_pkg::ROOT_W-1:0]    o_root
);
    logic                         r_busy, r_done;
    logic [ttacc_pkg::SQ_W-1:0]   r_x, r_res, r_bit;
    logic [ttacc_pkg::SQ_W-1:0]   w_trial;
    logic                         w_ge;

    assign w_trial = r_res + r_bit;
    assign w_ge    = (r_x >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_val;
            r_res <= '0;
            r_bit <= ttacc_pkg::SQ_W'(1) << (ttacc_pkg::SQ_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[ttacc_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

[sv/ttacc_dp.sv]
// Datapath: vertex and sum memories, tangent arithmetic, normalization, result register.
// Depends on ttacc_pkg, ttacc_div and ttacc_sqrt.
`default_nettype none
module ttacc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cap,
    input  wire logic [1:0]                        i_op,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_vert_index,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_z,
    input  wire logic signed [ttacc_pkg::UV_W-1:0] i_tex_u,
    input  wire logic signed [ttacc_pkg::UV_W-1:0] i_tex_v,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_a,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_b,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_c,
    input  wire ttacc_pkg::t_cmd                   i_cmd,
    output ttacc_pkg::t_stat                       o_stat,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_x,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_y,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_z,
    output logic [1:0]                             o_status
);
    localparam int PW = ttacc_pkg::POS_W;
    localparam int UW = ttacc_pkg::UV_W;
    localparam int SW = ttacc_pkg::SUM_W;
    localparam int TW = ttacc_pkg::TAN_W;
    localparam int NW = ttacc_pkg::NORM_W;
    localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};

    function automatic logic signed [SW-1:0] f_sat(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = (SW+1)'(a) + (SW+1)'(b);
        if (s[SW] != s[SW-1])
            return s[SW] ? {1'b1, {(SW-1){1'b0}}} : SUM_MAX;
        return s[SW-1:0];
    endfunction

    // captured item
    logic [1:0]                           r_op;
    logic [ttacc_pkg::IDX_W-1:0]          r_vi, r_ca, r_cb, r_cc;
    logic signed [PW-1:0]                 r_in_px, r_in_py, r_in_pz;
    logic signed [UW-1:0]                 r_in_u, r_in_v;

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_op    <= i_op;
            r_vi    <= i_vert_index;
            r_ca    <= i_corner_a;
            r_cb    <= i_corner_b;
            r_cc    <= i_corner_c;
            r_in_px <= i_pos_x;
            r_in_py <= i_pos_y;
            r_in_pz <= i_pos_z;
            r_in_u  <= i_tex_u;
            r_in_v  <= i_tex_v;
        end
    end

    logic [4:0] w_uop;
    assign w_uop = i_cmd.uop;

    logic [1:0] r_k, r_j;

    // vertex store
    logic signed [PW-1:0] m_px [ttacc_pkg::VERT_DEPTH];
    logic signed [PW-1:0] m_py [ttacc_pkg::VERT_DEPTH];
    logic signed [PW-1:0] m_pz [ttacc_pkg::VERT_DEPTH];
    logic signed [UW-1:0] m_u  [ttacc_pkg::VERT_DEPTH];
    logic signed [UW-1:0] m_v  [ttacc_pkg::VERT_DEPTH];
    logic signed [PW-1:0] r_rpx, r_rpy, r_rpz;
    logic signed [UW-1:0] r_ru, r_rv;
    logic [ttacc_pkg::IDX_W-1:0] w_vaddr, w_saddr, w_jaddr;
    logic w_vwr, w_vrd, w_swr, w_srd;

    assign w_vrd = (w_uop == ttacc_pkg::DP_RD_A) || (w_uop == ttacc_pkg::DP_RD_B) ||
                   (w_uop == ttacc_pkg::DP_RD_C);
    assign w_vwr = (w_uop == ttacc_pkg::DP_LOAD) && ttacc_pkg::f_idx_ok(r_vi);
    assign w_vaddr = (w_uop == ttacc_pkg::DP_RD_A) ? r_ca :
                     (w_uop == ttacc_pkg::DP_RD_B) ? r_cb :
                     (w_uop == ttacc_pkg::DP_RD_C) ? r_cc : r_vi;

    always_ff @(posedge i_clk) begin
        if (w_vwr) begin
            m_px[w_vaddr] <= r_in_px;
            m_py[w_vaddr] <= r_in_py;
            m_pz[w_vaddr] <= r_in_pz;
            m_u[w_vaddr]  <= r_in_u;
            m_v[w_vaddr]  <= r_in_v;
        end
        if (w_vrd) begin
            r_rpx <= m_px[w_vaddr];
            r_rpy <= m_py[w_vaddr];
            r_rpz <= m_pz[w_vaddr];
            r_ru  <= m_u[w_vaddr];
            r_rv  <= m_v[w_vaddr];
        end
    end

    // corner registers, filled in the cycle after each store read
    logic                 r_rd_pend;
    logic [1:0]           r_rd_slot;
    logic signed [PW-1:0] r_cpx [3];
    logic signed [PW-1:0] r_cpy [3];
    logic signed [PW-1:0] r_cpz [3];
    logic signed [UW-1:0] r_cu  [3];
    logic signed [UW-1:0] r_cv  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_pend <= 1'b0;
        else          r_rd_pend <= w_vrd;
    end

    always_ff @(posedge i_clk) begin
        if (w_vrd)
            r_rd_slot <= (w_uop == ttacc_pkg::DP_RD_A) ? 2'd0 :
                         (w_uop == ttacc_pkg::DP_RD_B) ? 2'd1 : 2'd2;
        if (r_rd_pend) begin
            r_cpx[r_rd_slot] <= r_rpx;
            r_cpy[r_rd_slot] <= r_rpy;
            r_cpz[r_rd_slot] <= r_rpz;
            r_cu[r_rd_slot]  <= r_ru;
            r_cv[r_rd_slot]  <= r_rv;
        end
    end

    // UV deltas and determinant
    logic signed [ttacc_pkg::DUV_W-1:0]   w_du1, w_dv1, w_du2, w_dv2;
    logic signed [2*ttacc_pkg::DUV_W-1:0] r_p1, r_p2;
    logic signed [ttacc_pkg::DET_W-1:0]   r_det;

    assign w_du1 = ttacc_pkg::DUV_W'(r_cu[1]) - ttacc_pkg::DUV_W'(r_cu[0]);
    assign w_dv1 = ttacc_pkg::DUV_W'(r_cv[1]) - ttacc_pkg::DUV_W'(r_cv[0]);
    assign w_du2 = ttacc_pkg::DUV_W'(r_cu[2]) - ttacc_pkg::DUV_W'(r_cu[0]);
    assign w_dv2 = ttacc_pkg::DUV_W'(r_cv[2]) - ttacc_pkg::DUV_W'(r_cv[0]);

    // numerator for component r_k
    logic signed [PW-1:0]                w_pa, w_pb, w_pc;
    logic signed [ttacc_pkg::E_W-1:0]    w_e1, w_e2;
    logic signed [ttacc_pkg::NP_W-1:0]   r_n1, r_n2;
    logic signed [ttacc_pkg::NUM_W-1:0]  r_num;

    assign w_pa = (r_k == 2'd0) ? r_cpx[0] : (r_k == 2'd1) ? r_cpy[0] : r_cpz[0];
    assign w_pb = (r_k == 2'd0) ? r_cpx[1] : (r_k == 2'd1) ? r_cpy[1] : r_cpz[1];
    assign w_pc = (r_k == 2'd0) ? r_cpx[2] : (r_k == 2'd1) ? r_cpy[2] : r_cpz[2];
    assign w_e1 = ttacc_pkg::E_W'(w_pb) - ttacc_pkg::E_W'(w_pa);
    assign w_e2 = ttacc_pkg::E_W'(w_pc) - ttacc_pkg::E_W'(w_pa);

    always_ff @(posedge i_clk) begin
        if (w_uop == ttacc_pkg::DP_UVMUL) begin
            r_p1 <= w_du1 * w_dv2;
            r_p2 <= w_du2 * w_dv1;
        end
        if (w_uop == ttacc_pkg::DP_DET)
            r_det <= ttacc_pkg::DET_W'(r_p1) - ttacc_pkg::DET_W'(r_p2);
        if (w_uop == ttacc_pkg::DP_NMUL) begin
            r_n1 <= w_dv2 * w_e1;
            r_n2 <= w_dv1 * w_e2;
        end
        if (w_uop == ttacc_pkg::DP_NUM)
            r_num <= ttacc_pkg::NUM_W'(r_n1) - ttacc_pkg::NUM_W'(r_n2);
    end

    // shared divider and square root
    logic [ttacc_pkg::NUM_W-1:0]   w_num_mag;
    logic [ttacc_pkg::DET_W-1:0]   w_det_mag;
    logic [ttacc_pkg::DIV_NW-1:0]  w_div_num, w_div_q;
    logic [ttacc_pkg::DIV_DW-1:0]  w_div_den;
    logic                          w_div_start, w_div_busy, w_div_done;
    logic                          w_sq_start, w_sq_busy, w_sq_done;
    logic [ttacc_pkg::ROOT_W-1:0]  w_root;
    logic [SW-1:0]                 r_mg [3];
    logic [ttacc_pkg::SQ_W-1:0]    r_acc;

    assign w_num_mag = r_num[ttacc_pkg::NUM_W-1] ? ttacc_pkg::NUM_W'(-r_num)
                                                 : ttacc_pkg::NUM_W'(r_num);
    assign w_det_mag = r_det[ttacc_pkg::DET_W-1] ? ttacc_pkg::DET_W'(-r_det)
                                                 : ttacc_pkg::DET_W'(r_det);
    assign w_div_start = (w_uop == ttacc_pkg::DP_TDIV) || (w_uop == ttacc_pkg::DP_UDIV);
    assign w_div_num = (w_uop == ttacc_pkg::DP_TDIV)
                     ? {w_num_mag[ttacc_pkg::DIV_NW-13:0], 12'd0}
                     : ttacc_pkg::DIV_NW'({r_mg[r_k][NW-1:0], 15'd0});
    assign w_div_den = (w_uop == ttacc_pkg::DP_TDIV) ? w_det_mag
                                                     : ttacc_pkg::DIV_DW'(w_root);
    assign w_sq_start = (w_uop == ttacc_pkg::DP_SQRT);

    ttacc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    ttacc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_acc),
        .o_busy  (w_sq_busy),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // tangent of the triangle, saturated to the sum range
    logic signed [SW-1:0] r_t [3];
    logic [SW-1:0]        w_qs;
    logic                 w_tneg;

    assign w_qs   = (|w_div_q[ttacc_pkg::DIV_NW-1:SW-1]) ? SUM_MAX : w_div_q[SW-1:0];
    assign w_tneg = r_num[ttacc_pkg::NUM_W-1] ^ r_det[ttacc_pkg::DET_W-1];

    always_ff @(posedge i_clk) begin
        if (w_uop == ttacc_pkg::DP_TSTORE)
            r_t[r_k] <= w_tneg ? SW'(-w_qs) : w_qs;
    end

    // sum store
    logic signed [SW-1:0] m_sx [ttacc_pkg::VERT_DEPTH];
    logic signed [SW-1:0] m_sy [ttacc_pkg::VERT_DEPTH];
    logic signed [SW-1:0] m_sz [ttacc_pkg::VERT_DEPTH];
    logic signed [SW-1:0] r_sq_x, r_sq_y, r_sq_z;
    logic signed [SW-1:0] w_wx, w_wy, w_wz;
    logic                 w_ld;

    assign w_jaddr = (r_j == 2'd0) ? r_ca : (r_j == 2'd1) ? r_cb : r_cc;
    assign w_ld    = (w_uop == ttacc_pkg::DP_LOAD);
    assign w_saddr = ((w_uop == ttacc_pkg::DP_SUMRD) || (w_uop == ttacc_pkg::DP_SUMWR))
                   ? w_jaddr : r_vi;
    assign w_srd = (w_uop == ttacc_pkg::DP_SUMRD) || (w_uop == ttacc_pkg::DP_VRD);
    assign w_swr = w_vwr || (w_uop == ttacc_pkg::DP_SUMWR);
    assign w_wx  = w_ld ? '0 : f_sat(r_sq_x, r_t[0]);
    assign w_wy  = w_ld ? '0 : f_sat(r_sq_y, r_t[1]);
    assign w_wz  = w_ld ? '0 : f_sat(r_sq_z, r_t[2]);

    always_ff @(posedge i_clk) begin
        if (w_swr) begin
            m_sx[w_saddr] <= w_wx;
            m_sy[w_saddr] <= w_wy;
            m_sz[w_saddr] <= w_wz;
        end
        if (w_srd) begin
            r_sq_x <= m_sx[w_saddr];
            r_sq_y <= m_sy[w_saddr];
            r_sq_z <= m_sz[w_saddr];
        end
    end

    // normalization
    logic [SW-1:0]        r_max, w_m01, w_max;
    logic [2*NW-1:0]      r_prod;
    logic signed [TW-1:0] r_u [3];
    logic [TW-1:0]        w_uq;
    logic                 w_sneg;

    assign w_m01 = (r_mg[0] > r_mg[1]) ? r_mg[0] : r_mg[1];
    assign w_max = (r_mg[2] > w_m01) ? r_mg[2] : w_m01;
    assign w_uq  = TW'((w_div_q[TW:0] + (TW+1)'(1)) >> 1);
    assign w_sneg = (r_k == 2'd0) ? r_sq_x[SW-1] : (r_k == 2'd1) ? r_sq_y[SW-1] : r_sq_z[SW-1];

    always_ff @(posedge i_clk) begin
        if (w_uop == ttacc_pkg::DP_VRD)
            r_acc <= '0;
        else if (w_uop == ttacc_pkg::DP_SQACC)
            r_acc <= r_acc + ttacc_pkg::SQ_W'(r_prod);
        if (w_uop == ttacc_pkg::DP_MAG) begin
            r_mg[0] <= r_sq_x[SW-1] ? SW'(-r_sq_x) : r_sq_x;
            r_mg[1] <= r_sq_y[SW-1] ? SW'(-r_sq_y) : r_sq_y;
            r_mg[2] <= r_sq_z[SW-1] ? SW'(-r_sq_z) : r_sq_z;
        end
        if (w_uop == ttacc_pkg::DP_MAX)
            r_max <= w_max;
        // truncate all magnitudes together until the largest fits
        if ((w_uop == ttacc_pkg::DP_SHIFT) && (|r_max[SW-1:NW])) begin
            r_max   <= r_max >> 1;
            r_mg[0] <= r_mg[0] >> 1;
            r_mg[1] <= r_mg[1] >> 1;
            r_mg[2] <= r_mg[2] >> 1;
        end
        if (w_uop == ttacc_pkg::DP_SQ)
            r_prod <= r_mg[r_k][NW-1:0] * r_mg[r_k][NW-1:0];
        if (w_uop == ttacc_pkg::DP_USTORE)
            r_u[r_k] <= w_sneg ? TW'(-w_uq) : w_uq;
    end

    // loop counters
    logic w_k_adv, w_k_last, w_j_last;
    assign w_k_last = (r_k == 2'd2);
    assign w_j_last = (r_j == 2'd2);
    assign w_k_adv  = (w_uop == ttacc_pkg::DP_TSTORE) || (w_uop == ttacc_pkg::DP_SQACC) ||
                      (w_uop == ttacc_pkg::DP_USTORE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_j <= '0;
        end else if ((w_uop == ttacc_pkg::DP_CLR) || (w_uop == ttacc_pkg::DP_VRD)) begin
            r_k <= '0;
            r_j <= '0;
        end else begin
            if (w_k_adv)
                r_k <= w_k_last ? 2'd0 : r_k + 2'd1;
            if (w_uop == ttacc_pkg::DP_SUMWR)
                r_j <= w_j_last ? 2'd0 : r_j + 2'd1;
        end
    end

    // result register
    logic signed [TW-1:0] r_ox, r_oy, r_oz;
    logic [1:0]           r_ost;
    logic                 w_tan_en;

    assign w_tan_en = (r_op == ttacc_pkg::OP_READ) && (i_cmd.status == ttacc_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (w_uop == ttacc_pkg::DP_RES) begin
            r_ost <= i_cmd.status;
            r_ox  <= w_tan_en ? r_u[0] : '0;
            r_oy  <= w_tan_en ? r_u[1] : '0;
            r_oz  <= w_tan_en ? r_u[2] : '0;
        end
    end

    assign o_tan_x  = r_ox;
    assign o_tan_y  = r_oy;
    assign o_tan_z  = r_oz;
    assign o_status = r_ost;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.idx_ok     = ttacc_pkg::f_idx_ok(r_vi);
        o_stat.tri_ok     = ttacc_pkg::f_idx_ok(r_ca) && ttacc_pkg::f_idx_ok(r_cb) &&
                            ttacc_pkg::f_idx_ok(r_cc);
        o_stat.det_zero   = (r_det == '0);
        o_stat.m_zero     = (r_max == '0);
        o_stat.shift_done = ~(|r_max[SW-1:NW]);
        o_stat.k_last     = w_k_last;
        o_stat.j_last     = w_j_last;
        o_stat.div_done   = w_div_done;
        o_stat.sqrt_done  = w_sq_done;
    end

`ifndef SYNTHESIS
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy) else $error("divider started while busy");
    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_start |-> !w_sq_busy) else $error("square root started while busy");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 2'd3) && (r_j != 2'd3)) else $error("component counter out of range");
`endif
endmodule
`default_nettype wire

[sv/ttacc_ctrl.sv]
// Controller state machine: sequences the datapath and owns both handshakes.
// Depends on ttacc_pkg for command and status types.
`default_nettype none
module ttacc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire ttacc_pkg::t_stat i_stat,
    output ttacc_pkg::t_cmd       o_cmd
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_RD_A   = 5'd3;
    localparam logic [4:0] S_RD_B   = 5'd4;
    localparam logic [4:0] S_RD_C   = 5'd5;
    localparam logic [4:0] S_RD_W   = 5'd6;
    localparam logic [4:0] S_UVMUL  = 5'd7;
    localparam logic [4:0] S_DET    = 5'd8;
    localparam logic [4:0] S_DETCHK = 5'd9;
    localparam logic [4:0] S_NMUL   = 5'd10;
    localparam logic [4:0] S_NUM    = 5'd11;
    localparam logic [4:0] S_TDIV   = 5'd12;
    localparam logic [4:0] S_TWAIT  = 5'd13;
    localparam logic [4:0] S_SUMRD  = 5'd14;
    localparam logic [4:0] S_SUMWR  = 5'd15;
    localparam logic [4:0] S_VRD    = 5'd16;
    localparam logic [4:0] S_MAG    = 5'd17;
    localparam logic [4:0] S_MAX    = 5'd18;
    localparam logic [4:0] S_ZCHK   = 5'd19;
    localparam logic [4:0] S_SHIFT  = 5'd20;
    localparam logic [4:0] S_SQ     = 5'd21;
    localparam logic [4:0] S_SQACC  = 5'd22;
    localparam logic [4:0] S_SQRT   = 5'd23;
    localparam logic [4:0] S_SQWAIT = 5'd24;
    localparam logic [4:0] S_UDIV   = 5'd25;
    localparam logic [4:0] S_UWAIT  = 5'd26;
    localparam logic [4:0] S_RES    = 5'd27;

    logic [4:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_oval, n_oval;
    logic [4:0] w_uop;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        w_uop    = ttacc_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                n_status = ttacc_pkg::ST_OK;
                unique case (i_stat.op)
                    ttacc_pkg::OP_LOAD: n_state = S_LOAD;
                    ttacc_pkg::OP_TRI: begin
                        if (i_stat.tri_ok) begin
                            n_state = S_RD_A;
                        end else begin
                            n_status = ttacc_pkg::ST_SKIP;
                            n_state  = S_RES;
                        end
                    end
                    ttacc_pkg::OP_READ: begin
                        if (i_stat.idx_ok) begin
                            n_state = S_VRD;
                        end else begin
                            n_status = ttacc_pkg::ST_ZERO;
                            n_state  = S_RES;
                        end
                    end
                    default: n_state = S_RES;
                endcase
            end
            S_LOAD: begin
                w_uop   = ttacc_pkg::DP_LOAD;
                n_state = S_RES;
            end
            S_RD_A: begin
                w_uop   = ttacc_pkg::DP_RD_A;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                w_uop   = ttacc_pkg::DP_RD_B;
                n_state = S_RD_C;
            end
            S_RD_C: begin
                w_uop   = ttacc_pkg::DP_RD_C;
                n_state = S_RD_W;
            end
            S_RD_W: n_state = S_UVMUL;
            S_UVMUL: begin
                w_uop   = ttacc_pkg::DP_UVMUL;
                n_state = S_DET;
            end
            S_DET: begin
                w_uop   = ttacc_pkg::DP_DET;
                n_state = S_DETCHK;
            end
            S_DETCHK: begin
                if (i_stat.det_zero) begin
                    n_status = ttacc_pkg::ST_SKIP;
                    n_state  = S_RES;
                end else begin
                    w_uop   = ttacc_pkg::DP_CLR;
                    n_state = S_NMUL;
                end
            end
            S_NMUL: begin
                w_uop   = ttacc_pkg::DP_NMUL;
                n_state = S_NUM;
            end
            S_NUM: begin
                w_uop   = ttacc_pkg::DP_NUM;
                n_state = S_TDIV;
            end
            S_TDIV: begin
                w_uop   = ttacc_pkg::DP_TDIV;
                n_state = S_TWAIT;
            end
            S_TWAIT: begin
                if (i_stat.div_done) begin
                    w_uop   = ttacc_pkg::DP_TSTORE;
                    n_state = i_stat.k_last ? S_SUMRD : S_NMUL;
                end
            end
            S_SUMRD: begin
                w_uop   = ttacc_pkg::DP_SUMRD;
                n_state = S_SUMWR;
            end
            S_SUMWR: begin
                w_uop   = ttacc_pkg::DP_SUMWR;
                n_state = i_stat.j_last ? S_RES : S_SUMRD;
            end
            S_VRD: begin
                w_uop   = ttacc_pkg::DP_VRD;
                n_state = S_MAG;
            end
            S_MAG: begin
                w_uop   = ttacc_pkg::DP_MAG;
                n_state = S_MAX;
            end
            S_MAX: begin
                w_uop   = ttacc_pkg::DP_MAX;
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                if (i_stat.m_zero) begin
                    n_status = ttacc_pkg::ST_ZERO;
                    n_state  = S_RES;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) n_state = S_SQ;
                else                   w_uop   = ttacc_pkg::DP_SHIFT;
            end
            S_SQ: begin
                w_uop   = ttacc_pkg::DP_SQ;
                n_state = S_SQACC;
            end
            S_SQACC: begin
                w_uop   = ttacc_pkg::DP_SQACC;
                n_state = i_stat.k_last ? S_SQRT : S_SQ;
            end
            S_SQRT: begin
                w_uop   = ttacc_pkg::DP_SQRT;
                n_state = S_SQWAIT;
            end
            S_SQWAIT: begin
                if (i_stat.sqrt_done) n_state = S_UDIV;
            end
            S_UDIV: begin
                w_uop   = ttacc_pkg::DP_UDIV;
                n_state = S_UWAIT;
            end
            S_UWAIT: begin
                if (i_stat.div_done) begin
                    w_uop   = ttacc_pkg::DP_USTORE;
                    n_state = i_stat.k_last ? S_RES : S_UDIV;
                end
            end
            S_RES: begin
                // hold until the result register is free
                if (!r_oval || i_out_ready) begin
                    w_uop   = ttacc_pkg::DP_RES;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_uop == ttacc_pkg::DP_RES) n_oval = 1'b1;
        else if (i_out_ready)           n_oval = 1'b0;
        else                            n_oval = r_oval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ttacc_pkg::ST_OK;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_oval   <= n_oval;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_oval;
    assign o_cmd.uop    = w_uop;
    assign o_cmd.status = r_status;

`ifndef SYNTHESIS
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP))
        else $error("accepted beat did not start dispatch");
    a_rise_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_RES))
        else $error("result raised outside result state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && o_out_valid && !i_out_ready) |=> (r_state == S_RES))
        else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire

[sv/triangle_tangent_accumulator_unit.sv]
// A load writes one vertex and clears its sum; a triangle computes three tangent components,
// each with a division, and adds them to the corner sums; a read shifts the sums into range,
// takes one square root and does three divisions. Items are handled one at a time.
// Reset (i_rst_n low, synchronous) clears control only; memories need a load first.
`default_nettype none
module triangle_tangent_accumulator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_op,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_vert_index,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [ttacc_pkg::POS_W-1:0] i_pos_z,
    input  wire logic signed [ttacc_pkg::UV_W-1:0] i_tex_u,
    input  wire logic signed [ttacc_pkg::UV_W-1:0] i_tex_v,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_a,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_b,
    input  wire logic [ttacc_pkg::IDX_W-1:0]       i_corner_c,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_x,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_y,
    output logic signed [ttacc_pkg::TAN_W-1:0]     o_tan_z,
    output logic [1:0]                             o_status
);
    ttacc_pkg::t_cmd  w_cmd;
    ttacc_pkg::t_stat w_stat;
    logic             w_cap;

    assign w_cap = i_in_valid && o_in_ready;

    ttacc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ttacc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (w_cap),
        .i_op         (i_op),
        .i_vert_index (i_vert_index),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_tex_u      (i_tex_u),
        .i_tex_v      (i_tex_v),
        .i_corner_a   (i_corner_a),
        .i_corner_b   (i_corner_b),
        .i_corner_c   (i_corner_c),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_tan_x      (o_tan_x),
        .o_tan_y      (o_tan_y),
        .o_tan_z      (o_tan_z),
        .o_status     (o_status)
    );
endmodule
`default_nettype wire
